// ===== hdl/pilru_pkg.sv =====
// Shared types and constants for the predictive-insertion LRU replacement block.
`timescale 1ns / 1ps
package pilru_pkg;

  localparam int OP_W   = 2;
  localparam int THR_W  = 9;
  localparam int LIM_W  = 7;
  localparam int CTR_W  = 8;
  localparam int CLS_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_VICTIM = 2'd0;
  localparam logic [OP_W-1:0] OP_HIT    = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // Stored prediction codes
  localparam logic [1:0] PRED_MIDDLE = 2'd0;
  localparam logic [1:0] PRED_NEAR   = 2'd1;
  localparam logic [1:0] PRED_FAR    = 2'd2;

  // Output class codes
  localparam logic [CLS_W-1:0] CLS_FAR    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MIDDLE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_NEAR   = 2'd2;

  // Configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_LIMIT     = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_en;   // sweep step of the post-reset clear pass
    logic capture;    // latch input word, issue reads
    logic compute;    // read data valid, compute and write back
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;
  } dp_status_t;

endpackage

// ===== hdl/pilru_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module pilru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pilru_ctrl.sv =====
// Controller state machine: clear pass, then read / write per accepted word.
`timescale 1ns / 1ps
module pilru_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pilru_pkg::ctrl_cmd_t   cmd,
  input  pilru_pkg::dp_status_t status
);
  import pilru_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.compute = 1'b1;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        // Take the next word while the result is handed off
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_next  = ST_READ;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready) else $error("accept during clear");
  a_compute_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.compute |-> $past(cmd.capture)) else $error("compute without capture");
  a_out_after_compute: assert property (@(posedge clk) disable iff (rst)
    cmd.compute |=> out_valid) else $error("result missing");
`endif

endmodule

// ===== hdl/pilru_dp.sv =====
// Datapath: set row memory, predictor tables, history, result register.
`timescale 1ns / 1ps
module pilru_dp #(
  parameter int NUM_SETS      = 2048,
  parameter int NUM_WAYS      = 16,
  parameter int TABLE_ENTRIES = 512,
  parameter int HISTORY_DEPTH = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pilru_pkg::ctrl_cmd_t     cmd,
  output pilru_pkg::dp_status_t    status,
  input  logic                     cfg_we,
  input  logic                     cfg_idx,
  input  logic [8:0]               cfg_data,
  input  logic [1:0]               operation,
  input  logic [10:0]              set_index,
  input  logic [3:0]               way_index,
  input  logic [63:0]              phys_address,
  input  logic [63:0]              program_counter,
  output logic [3:0]               victim_way,
  output logic [1:0]               predicted_class,
  output logic [3:0]               insert_age
);
  import pilru_pkg::*;

  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SET_D  = 1 << SET_W;
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int HASH_W = $clog2(TABLE_ENTRIES);
  localparam int ENT_W  = WAY_W + 3;      // age, not_reused, prediction
  localparam int ROW_W  = ENT_W * NUM_WAYS;
  localparam int CLR_W  = (SET_W > HASH_W) ? SET_W : HASH_W;
  localparam int CLR_N  = (SET_D > TABLE_ENTRIES) ? SET_D : TABLE_ENTRIES;
  localparam int SUM_W  = CTR_W + 2;
  localparam logic [WAY_W-1:0] AGE_MAX = WAY_W'(NUM_WAYS - 1);
  localparam logic [WAY_W-1:0] AGE_MID = WAY_W'(NUM_WAYS / 2 - 1);

  // Configuration registers
  logic [THR_W-1:0] threshold;
  logic [LIM_W-1:0] limit;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_W'(4);
      limit     <= LIM_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_THRESHOLD: threshold <= cfg_data;
        REG_LIMIT:     limit     <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clear sweep counter
  logic [CLR_W:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en && !status.clear_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end
  assign status.clear_done = (clr_cnt == (CLR_W+1)'(CLR_N - 1));

  // Captured input word
  logic [1:0]        op_q;
  logic [SET_W-1:0]  set_q;
  logic [WAY_W-1:0]  way_q;
  logic [HASH_W-1:0] h1_q, h2_q, h3_q;
  logic [HASH_W-1:0] hist [HISTORY_DEPTH];
  logic [HASH_W-1:0] pc_hash, h3_old, h3_new;

  assign pc_hash = program_counter[2 +: HASH_W];

  // Fold history before and after the shift
  always_comb begin
    h3_old = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) h3_old ^= hist[i];
    h3_new = pc_hash;
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) h3_new ^= hist[i];
  end

  logic push;
  assign push = cmd.capture && (operation == OP_HIT || operation == OP_FILL);

  // Capture word and shift history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] <= '0;
    end else if (push) begin
      hist[0] <= pc_hash;
      for (int i = 1; i < HISTORY_DEPTH; i++) hist[i] <= hist[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= operation;
      set_q <= SET_W'(32'(set_index) % NUM_SETS);
      way_q <= WAY_W'(32'(way_index) % NUM_WAYS);
      h1_q  <= phys_address[6 +: HASH_W];
      h2_q  <= pc_hash;
      h3_q  <= (operation == OP_FILL) ? h3_new : h3_old;
    end
  end

  // Reset row of a set
  function automatic logic [ROW_W-1:0] reset_row();
    logic [ROW_W-1:0] r;
    for (int w = 0; w < NUM_WAYS; w++)
      r[w*ENT_W +: ENT_W] = {WAY_W'(w), 1'b1, PRED_MIDDLE};
    return r;
  endfunction

  // Memories
  logic              row_we, t_we;
  logic [SET_W-1:0]  row_waddr;
  logic [ROW_W-1:0]  row_wdata, row_rdata;
  logic [HASH_W-1:0] a_waddr, p_waddr, y_waddr;
  logic [CTR_W-1:0]  a_wdata, p_wdata, y_wdata, a_rd, p_rd, y_rd;
  logic [SET_W-1:0]  row_raddr;
  logic [HASH_W-1:0] a_raddr, p_raddr, y_raddr;

  assign row_raddr = SET_W'(32'(set_index) % NUM_SETS);
  assign a_raddr   = phys_address[6 +: HASH_W];
  assign p_raddr   = pc_hash;
  assign y_raddr   = (operation == OP_FILL) ? h3_new : h3_old;

  pilru_ram #(.WIDTH(ROW_W), .DEPTH(SET_D)) u_rows (
    .clk, .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata));
  pilru_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_atab (
    .clk, .we(t_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rd));
  pilru_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_ptab (
    .clk, .we(t_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rd));
  pilru_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_htab (
    .clk, .we(t_we), .waddr(y_waddr), .wdata(y_wdata),
    .raddr(y_raddr), .rdata(y_rd));

  // Saturating counter step
  function automatic logic [CTR_W-1:0] bump(input logic [CTR_W-1:0] c,
                                             input logic up,
                                             input logic [LIM_W-1:0] lim);
    logic signed [CTR_W:0] v, l;
    v = {c[CTR_W-1], c};
    l = {2'b00, lim};
    if (up && v < l) v = v + $signed((CTR_W+1)'(1));
    else if (!up && v > -l) v = v - $signed((CTR_W+1)'(1));
    return v[CTR_W-1:0];
  endfunction

  // Row update and result
  logic [WAY_W-1:0]  vic, cur, pos;
  logic [1:0]        pv;
  logic              nrv, do_train, up;
  logic [1:0]        cls;
  logic [1:0]        newpred;
  logic signed [SUM_W-1:0] sum, thr;
  logic [ROW_W-1:0]  row_new;

  always_comb begin
    vic = '0;
    for (int w = 0; w < NUM_WAYS; w++)
      if (row_rdata[w*ENT_W+3 +: WAY_W] == AGE_MAX) vic = WAY_W'(w);
    pv  = row_rdata[32'(vic)*ENT_W +: 2];
    nrv = row_rdata[32'(vic)*ENT_W + 2];
    cur = row_rdata[32'(way_q)*ENT_W+3 +: WAY_W];
    do_train = nrv ? (pv != PRED_FAR) : (pv != PRED_NEAR);
    up  = !nrv;
    sum = SUM_W'($signed(a_rd)) + SUM_W'($signed(p_rd)) + SUM_W'($signed(y_rd));
    thr = SUM_W'({1'b0, threshold});
    if (sum < -thr) begin
      cls = CLS_FAR;    pos = AGE_MAX; newpred = PRED_FAR;
    end else if (sum > thr) begin
      cls = CLS_NEAR;   pos = '0;      newpred = PRED_NEAR;
    end else begin
      cls = CLS_MIDDLE; pos = AGE_MID; newpred = PRED_MIDDLE;
    end
    row_new = row_rdata;
    for (int w = 0; w < NUM_WAYS; w++) begin
      logic [WAY_W-1:0] a;
      a = row_rdata[w*ENT_W+3 +: WAY_W];
      if (op_q == OP_HIT) begin
        if (a < cur) row_new[w*ENT_W+3 +: WAY_W] = a + 1'b1;
        if (WAY_W'(w) == way_q) row_new[w*ENT_W +: ENT_W] =
          {{WAY_W{1'b0}}, 1'b0, row_rdata[w*ENT_W +: 2]};
      end else begin
        if (a >= pos && a < AGE_MAX) row_new[w*ENT_W+3 +: WAY_W] = a + 1'b1;
        if (WAY_W'(w) == way_q) row_new[w*ENT_W +: ENT_W] = {pos, 1'b1, newpred};
      end
    end
  end

  // Write ports: clear sweep or write-back
  always_comb begin
    if (cmd.clear_en) begin
      row_we    = (32'(clr_cnt) < SET_D);
      row_waddr = clr_cnt[SET_W-1:0];
      row_wdata = reset_row();
      t_we      = (32'(clr_cnt) < TABLE_ENTRIES);
      a_waddr   = clr_cnt[HASH_W-1:0];
      p_waddr   = clr_cnt[HASH_W-1:0];
      y_waddr   = clr_cnt[HASH_W-1:0];
      a_wdata   = '0;
      p_wdata   = '0;
      y_wdata   = '0;
    end else begin
      row_we    = cmd.compute && (op_q == OP_HIT || op_q == OP_FILL);
      row_waddr = set_q;
      row_wdata = row_new;
      t_we      = cmd.compute && (op_q == OP_VICTIM) && do_train;
      a_waddr   = h1_q;
      p_waddr   = h2_q;
      y_waddr   = h3_q;
      a_wdata   = bump(a_rd, up, limit);
      p_wdata   = bump(p_rd, up, limit);
      y_wdata   = bump(y_rd, up, limit);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.compute) begin
      victim_way      <= (op_q == OP_VICTIM) ? 4'(vic) : 4'd0;
      predicted_class <= (op_q == OP_FILL) ? cls : CLS_MIDDLE;
      insert_age      <= (op_q == OP_FILL) ? 4'(pos) : 4'd0;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.compute && cmd.clear_en)) else $error("clear and compute overlap");
  a_no_train_on_fill: assert property (@(posedge clk) disable iff (rst)
    (cmd.compute && op_q != OP_VICTIM) |-> !t_we) else $error("stray train");
  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    status.clear_done |=> status.clear_done) else $error("clear restarted");
`endif

endmodule

// ===== hdl/predictive_insertion_lru_replacement.sv =====
// Top level: predictive-insertion LRU replacement with hashed reuse predictor.
//
//  channel   signals                                       direction
//  input     in_valid/in_ready, operation..program_counter  in
//  output    out_valid/out_ready, victim_way..insert_age    out
//  config    cfg_we, cfg_index, cfg_data                    in
//
// Each word first reads the set row and counters from RAM, then updates
// and writes them back. The next word is taken as the result is handed
// off. After reset a clear pass over max(NUM_SETS rounded to a power of
// two, TABLE_ENTRIES) addresses runs before the first word is taken.
// A stalled output holds the result and blocks new input.
`timescale 1ns / 1ps
module predictive_insertion_lru_replacement #(
  parameter int NUM_SETS      = 2048,
  parameter int NUM_WAYS      = 16,
  parameter int TABLE_ENTRIES = 512,
  parameter int HISTORY_DEPTH = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [10:0] set_index,
  input  logic [3:0]  way_index,
  input  logic [63:0] phys_address,
  input  logic [63:0] program_counter,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  victim_way,
  output logic [1:0]  predicted_class,
  output logic [3:0]  insert_age,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  import pilru_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pilru_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd, .status);

  pilru_dp #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
    .TABLE_ENTRIES(TABLE_ENTRIES), .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk, .rst, .cmd, .status,
    .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .operation, .set_index, .way_index, .phys_address, .program_counter,
    .victim_way, .predicted_class, .insert_age);

endmodule
